@@ rtl/core/sdft_pkg.sv @@
package sdft_pkg;

  localparam int BINS = 16;
  localparam int BIN_W = 4;
  localparam int CNT_W = 5;
  localparam int SQRT_STEPS = 32;

  localparam logic [1:0] KIND_PUSH = 2'd0;
  localparam logic [1:0] KIND_MAG = 2'd1;
  localparam logic [1:0] KIND_PEAK = 2'd2;

  localparam logic [30:0] MAG_SAT = 31'h7FFF_FFFF;

  typedef struct packed {
    logic             push_start;
    logic             rot_issue;
    logic             pwr_issue;
    logic             pwr_peak;
    logic             peak_clear;
    logic             sqrt_start;
    logic             sqrt_step;
    logic             load_mag;
    logic             load_peak;
    logic [BIN_W-1:0] addr;
  } sdft_cmd_t;

  function automatic logic signed [15:0] sdft_cos(input logic [BIN_W-1:0] k);
    logic signed [15:0] v;
    case (k)
      4'd0:    v = 16'sd32767;
      4'd1:    v = 16'sd30272;
      4'd2:    v = 16'sd23169;
      4'd3:    v = 16'sd12539;
      4'd4:    v = 16'sd0;
      4'd5:    v = -16'sd12539;
      4'd6:    v = -16'sd23169;
      4'd7:    v = -16'sd30272;
      4'd8:    v = -16'sd32767;
      4'd9:    v = -16'sd30272;
      4'd10:   v = -16'sd23169;
      4'd11:   v = -16'sd12539;
      4'd12:   v = 16'sd0;
      4'd13:   v = 16'sd12539;
      4'd14:   v = 16'sd23169;
      4'd15:   v = 16'sd30272;
      default: v = 16'sd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [15:0] sdft_sin(input logic [BIN_W-1:0] k);
    logic signed [15:0] v;
    case (k)
      4'd0:    v = 16'sd0;
      4'd1:    v = 16'sd12539;
      4'd2:    v = 16'sd23169;
      4'd3:    v = 16'sd30272;
      4'd4:    v = 16'sd32767;
      4'd5:    v = 16'sd30272;
      4'd6:    v = 16'sd23169;
      4'd7:    v = 16'sd12539;
      4'd8:    v = 16'sd0;
      4'd9:    v = -16'sd12539;
      4'd10:   v = -16'sd23169;
      4'd11:   v = -16'sd30272;
      4'd12:   v = -16'sd32767;
      4'd13:   v = -16'sd30272;
      4'd14:   v = -16'sd23169;
      4'd15:   v = -16'sd12539;
      default: v = 16'sd0;
    endcase
    return v;
  endfunction

endpackage

@@ rtl/core/sliding_dft_bins_core.sv @@
// Sliding DFT over 16 bins in Q15 fixed point.
// The input channel carries a kind code with a sample and a bin index.
// A push transfer replaces the oldest sample in the delay line and then
// rotates all 16 bins through one shared complex multiplier, one bin per
// cycle, then drains the multiplier; it produces no result.
// A magnitude query squares one bin, then runs a bit-serial square root
// of 32 steps; its result is registered once the output register is free.
// A peak query scans the powers of bins 1 to 15 one per cycle and
// returns the strongest bin, the lowest index winning a tie.
// The block works on one item at a time and holds in_stall high while busy.
// A result sits in an output register until the receiver takes it, so a
// new item is accepted while a result waits; a second result then waits
// in the block until the output register frees up.
// Synchronous reset clears all bins, the delay line, the write position
// and the output valid flag.
module sliding_dft_bins_core import sdft_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_kind,
  input  logic signed [15:0] in_sample,
  input  logic [3:0]         in_bin,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [30:0]        out_magnitude,
  output logic [3:0]         out_peak_bin
);

  sdft_cmd_t cmd;

  sdft_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_kind   (in_kind),
    .in_bin    (in_bin),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  sdft_dpath u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .in_sample     (in_sample),
    .out_magnitude (out_magnitude),
    .out_peak_bin  (out_peak_bin)
  );

endmodule

@@ rtl/core/sdft_dpath.sv @@
module sdft_dpath import sdft_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  sdft_cmd_t               cmd,
  input  logic signed [15:0]      in_sample,
  output logic [30:0]             out_magnitude,
  output logic [BIN_W-1:0]        out_peak_bin
);

  logic signed [31:0] re_r [BINS];
  logic signed [31:0] im_r [BINS];
  logic signed [15:0] hist_r [BINS];
  logic [BIN_W-1:0]   wpos_r;
  logic signed [31:0] diff_r;

  logic signed [47:0] p_rc_r, p_is_r, p_rs_r, p_ic_r;
  logic [BIN_W-1:0]   rot_addr_r;
  logic               rot_v_r;

  logic signed [63:0] sq_re_r, sq_im_r;
  logic               sq_v_r, sq_pk_r, pw_v_r, pw_pk_r;
  logic [BIN_W-1:0]   sq_addr_r, pw_addr_r;
  logic [63:0]        pwr_r;
  logic [63:0]        best_r;
  logic [BIN_W-1:0]   best_bin_r;

  logic [63:0]        rad_r;
  logic [33:0]        rem_r;
  logic [31:0]        root_r;

  logic [30:0]        mag_r;
  logic [BIN_W-1:0]   peak_r;

  logic signed [31:0] rd_re, rd_im;
  logic signed [15:0] rd_cos, rd_sin;
  logic signed [48:0] rr, ri, rr_sh, ri_sh;
  logic signed [31:0] re_new, im_new;
  logic signed [16:0] dsmp;
  logic [34:0]        rem_sh, trial;

  assign rd_re  = re_r[cmd.addr];
  assign rd_im  = im_r[cmd.addr];
  assign rd_cos = sdft_cos(cmd.addr);
  assign rd_sin = sdft_sin(cmd.addr);

  assign rr     = 49'(p_rc_r) - 49'(p_is_r);
  assign ri     = 49'(p_rs_r) + 49'(p_ic_r);
  assign rr_sh  = rr >>> 15;
  assign ri_sh  = ri >>> 15;
  assign re_new = rr_sh[31:0] + diff_r;
  assign im_new = ri_sh[31:0];

  assign dsmp   = 17'(in_sample) - 17'(hist_r[wpos_r]);

  assign rem_sh = {rem_r[32:0], rad_r[63:62]};
  assign trial  = {1'b0, root_r, 2'b01};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < BINS; i++) begin
        re_r[i]   <= '0;
        im_r[i]   <= '0;
        hist_r[i] <= '0;
      end
      wpos_r  <= '0;
      rot_v_r <= 1'b0;
      sq_v_r  <= 1'b0;
      pw_v_r  <= 1'b0;
    end else begin
      if (cmd.push_start) begin
        hist_r[wpos_r] <= in_sample;
        wpos_r         <= wpos_r + 1'b1;
      end
      rot_v_r <= cmd.rot_issue;
      if (rot_v_r) begin
        re_r[rot_addr_r] <= re_new;
        im_r[rot_addr_r] <= im_new;
      end
      sq_v_r <= cmd.pwr_issue;
      pw_v_r <= sq_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push_start) begin
      diff_r <= {{2{dsmp[16]}}, dsmp, 13'b0};
    end
    p_rc_r     <= rd_re * rd_cos;
    p_is_r     <= rd_im * rd_sin;
    p_rs_r     <= rd_re * rd_sin;
    p_ic_r     <= rd_im * rd_cos;
    rot_addr_r <= cmd.addr;

    sq_re_r   <= rd_re * rd_re;
    sq_im_r   <= rd_im * rd_im;
    sq_addr_r <= cmd.addr;
    sq_pk_r   <= cmd.pwr_peak;
    pwr_r     <= 64'(sq_re_r) + 64'(sq_im_r);
    pw_addr_r <= sq_addr_r;
    pw_pk_r   <= sq_pk_r;

    if (cmd.peak_clear) begin
      best_r     <= '0;
      best_bin_r <= BIN_W'(1);
    end else if (pw_v_r && pw_pk_r && (pwr_r > best_r)) begin
      best_r     <= pwr_r;
      best_bin_r <= pw_addr_r;
    end

    if (cmd.sqrt_start) begin
      rad_r  <= pwr_r;
      rem_r  <= '0;
      root_r <= '0;
    end else if (cmd.sqrt_step) begin
      rad_r <= {rad_r[61:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_r  <= 34'(rem_sh - trial);
        root_r <= {root_r[30:0], 1'b1};
      end else begin
        rem_r  <= rem_sh[33:0];
        root_r <= {root_r[30:0], 1'b0};
      end
    end

    if (cmd.load_mag) begin
      mag_r  <= root_r[31] ? MAG_SAT : root_r[30:0];
      peak_r <= '0;
    end else if (cmd.load_peak) begin
      mag_r  <= '0;
      peak_r <= best_bin_r;
    end
  end

  assign out_magnitude = mag_r;
  assign out_peak_bin  = peak_r;

endmodule

@@ rtl/core/sdft_ctrl.sv @@
module sdft_ctrl import sdft_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [1:0]       in_kind,
  input  logic [BIN_W-1:0] in_bin,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  output sdft_cmd_t        cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROT,
    ST_ROT_DRAIN,
    ST_PEAK,
    ST_WAIT1,
    ST_WAIT2,
    ST_SQRT,
    ST_RESULT
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             is_peak_r, is_peak_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             accept;
  logic             out_free;

  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && (state_r == ST_IDLE);
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    is_peak_nxt   = is_peak_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    cmd.addr      = cnt_r[BIN_W-1:0];
    case (state_r)
      ST_IDLE: begin
        cmd.addr = in_bin;
        if (accept) begin
          case (in_kind)
            KIND_PUSH: begin
              cmd.push_start = 1'b1;
              cnt_nxt        = '0;
              state_nxt      = ST_ROT;
            end
            KIND_MAG: begin
              cmd.pwr_issue = 1'b1;
              is_peak_nxt   = 1'b0;
              state_nxt     = ST_WAIT1;
            end
            KIND_PEAK: begin
              cmd.peak_clear = 1'b1;
              is_peak_nxt    = 1'b1;
              cnt_nxt        = CNT_W'(1);
              state_nxt      = ST_PEAK;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_ROT: begin
        cmd.rot_issue = 1'b1;
        cnt_nxt       = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(BINS - 1)) begin
          state_nxt = ST_ROT_DRAIN;
        end
      end
      ST_ROT_DRAIN: begin
        state_nxt = ST_IDLE;
      end
      ST_PEAK: begin
        cmd.pwr_issue = 1'b1;
        cmd.pwr_peak  = 1'b1;
        cnt_nxt       = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(BINS - 1)) begin
          state_nxt = ST_WAIT1;
        end
      end
      ST_WAIT1: begin
        state_nxt = ST_WAIT2;
      end
      ST_WAIT2: begin
        if (is_peak_r) begin
          state_nxt = ST_RESULT;
        end else begin
          cmd.sqrt_start = 1'b1;
          cnt_nxt        = '0;
          state_nxt      = ST_SQRT;
        end
      end
      ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
        cnt_nxt       = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(SQRT_STEPS - 1)) begin
          state_nxt = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (out_free) begin
          cmd.load_mag  = !is_peak_r;
          cmd.load_peak = is_peak_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      is_peak_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      is_peak_r   <= is_peak_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ rtl/core/sdft_checker.sv @@
module sdft_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic [1:0]  in_kind,
  input logic        out_valid,
  input logic        out_stall,
  input logic [30:0] out_magnitude,
  input logic [3:0]  out_peak_bin
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_magnitude) && $stable(out_peak_bin))
    else $error("stalled result changed");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_one_field: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_peak_bin != 4'd0) |-> out_magnitude == 31'd0)
    else $error("peak result carries a magnitude");

  a_push_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_kind == 2'd0) |=> in_stall)
    else $error("push transfer did not occupy the block");

endmodule

bind sliding_dft_bins_core sdft_checker u_sdft_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .in_kind       (in_kind),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_magnitude (out_magnitude),
  .out_peak_bin  (out_peak_bin)
);

@@ test/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import sdft_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 700;
  localparam int HOLD_CYCLES = 400;

  typedef struct {
    logic [1:0]         kind;
    logic signed [15:0] sample;
    logic [3:0]         bin;
    bit                 typed;
    bit [30:0]          mag;
    bit [3:0]           peak;
  } row_t;

  typedef struct {
    bit [30:0] mag;
    bit [3:0]  peak;
  } bin_result_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [1:0]         in_kind;
  logic signed [15:0] in_sample;
  logic [3:0]         in_bin;
  logic               out_valid;
  logic               out_stall;
  logic [30:0]        out_magnitude;
  logic [3:0]         out_peak_bin;

  int cos_q15[16] = '{32767, 30272, 23169, 12539, 0, -12539, -23169, -30272,
                      -32767, -30272, -23169, -12539, 0, 12539, 23169, 30272};
  int sin_q15[16] = '{0, 12539, 23169, 30272, 32767, 30272, 23169, 12539,
                      0, -12539, -23169, -30272, -32767, -30272, -23169, -12539};

  logic signed [31:0] bin_re[16];
  logic signed [31:0] bin_im[16];
  logic signed [15:0] delay_line[16];
  logic [3:0]         slot;

  bin_result_t pending_results[$];
  int errors = 0;
  int transfers = 0;
  bit hold_done = 0;
  int hold_left = 0;

  row_t plan[18] = '{
    '{KIND_MAG, 16'sd0, 4'd0, 1, 31'd0, 4'd0},
    '{KIND_MAG, 16'sd0, 4'd15, 1, 31'd0, 4'd0},
    '{KIND_PEAK, 16'sd0, 4'd0, 1, 31'd0, 4'd1},
    '{KIND_UNUSED, -16'sd1, 4'd15, 0, 31'd0, 4'd0},
    '{KIND_PEAK, 16'sd0, 4'd0, 1, 31'd0, 4'd1},
    '{KIND_PUSH, 16'sd32767, 4'd0, 0, 31'd0, 4'd0},
    '{KIND_MAG, 16'sd0, 4'd0, 0, 31'd0, 4'd0},
    '{KIND_MAG, 16'sd0, 4'd8, 0, 31'd0, 4'd0},
    '{KIND_PUSH, -16'sd32768, 4'd15, 0, 31'd0, 4'd0},
    '{KIND_MAG, 16'sd0, 4'd1, 0, 31'd0, 4'd0},
    '{KIND_PEAK, 16'sd0, 4'd0, 0, 31'd0, 4'd0},
    '{KIND_PUSH, 16'sd32767, 4'd0, 0, 31'd0, 4'd0},
    '{KIND_PUSH, -16'sd32768, 4'd0, 0, 31'd0, 4'd0},
    '{KIND_PUSH, 16'sd32767, 4'd0, 0, 31'd0, 4'd0},
    '{KIND_MAG, 16'sd0, 4'd8, 0, 31'd0, 4'd0},
    '{KIND_MAG, 16'sd0, 4'd15, 0, 31'd0, 4'd0},
    '{KIND_PEAK, 16'sd0, 4'd0, 0, 31'd0, 4'd0},
    '{KIND_PUSH, 16'sd0, 4'd0, 0, 31'd0, 4'd0}
  };

  sliding_dft_bins_core uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_kind(in_kind), .in_sample(in_sample), .in_bin(in_bin),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_magnitude(out_magnitude), .out_peak_bin(out_peak_bin)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  function automatic bit [63:0] bin_power(int k);
    longint r;
    longint i;
    bit [63:0] ar;
    bit [63:0] ai;
    r = bin_re[k];
    i = bin_im[k];
    ar = (r < 0) ? -r : r;
    ai = (i < 0) ? -i : i;
    return ar * ar + ai * ai;
  endfunction

  function automatic bit [63:0] floor_sqrt(bit [63:0] x);
    bit [63:0] res;
    bit [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  task automatic slide_sample(logic signed [15:0] s);
    longint prev;
    longint diff;
    longint rr;
    longint ri;
    prev = delay_line[slot];
    delay_line[slot] = s;
    slot = slot + 4'd1;
    diff = (longint'(s) - prev) * 131072 / 16;
    for (int k = 0; k < 16; k++) begin
      rr = longint'(bin_re[k]) * cos_q15[k] - longint'(bin_im[k]) * sin_q15[k];
      ri = longint'(bin_re[k]) * sin_q15[k] + longint'(bin_im[k]) * cos_q15[k];
      bin_re[k] = 32'((rr >>> 15) + diff);
      bin_im[k] = 32'(ri >>> 15);
    end
  endtask

  task automatic predict_item(logic [1:0] kind, logic signed [15:0] s, logic [3:0] b,
                              output bit has_result, output bin_result_t r);
    bit [63:0] m;
    bit [63:0] best_p;
    has_result = 0;
    r = '{0, 0};
    if (kind == KIND_PUSH) begin
      slide_sample(s);
    end else if (kind == KIND_MAG) begin
      m = floor_sqrt(bin_power(b));
      if (m > 64'h7FFF_FFFF) m = 64'h7FFF_FFFF;
      r.mag = m[30:0];
      has_result = 1;
    end else if (kind == KIND_PEAK) begin
      best_p = 0;
      r.peak = 4'd1;
      for (int k = 1; k < 16; k++) begin
        if (bin_power(k) > best_p) begin
          best_p = bin_power(k);
          r.peak = 4'(k);
        end
      end
      has_result = 1;
    end
  endtask

  task automatic send_item(row_t row, bit may_idle);
    bit has_result;
    bin_result_t r;
    while (may_idle && $urandom_range(99) < 28) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= row.kind;
    in_sample <= row.sample;
    in_bin <= row.bin;
    do @(posedge clk); while (in_stall);
    predict_item(row.kind, row.sample, row.bin, has_result, r);
    if (row.typed) begin
      r.mag = row.mag;
      r.peak = row.peak;
    end
    if (has_result) pending_results.push_back(r);
    transfers++;
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  always @(posedge clk) begin
    bin_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected transfer, magnitude", out_magnitude, -1);
      end else begin
        want = pending_results.pop_front();
        if (out_magnitude !== want.mag) report_mismatch("magnitude", out_magnitude, want.mag);
        if (out_peak_bin !== want.peak) report_mismatch("peak_bin", out_peak_bin, want.peak);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else if (!hold_done && transfers >= 150) begin
      hold_done = 1;
      hold_left = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (transfers >= 300 && transfers < 450) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < 28);
    end
  end

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    row_t row;
    int n;
    int tone;
    int phase;
    int pick;
    for (int k = 0; k < 16; k++) begin
      bin_re[k] = 0;
      bin_im[k] = 0;
      delay_line[k] = 0;
    end
    slot = 0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_kind <= KIND_PUSH;
    in_sample <= 16'sd0;
    in_bin <= 4'd0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) send_item(plan[i], 1'b0);

    n = 0;
    tone = 1;
    phase = 0;
    while (n < RANDOM_ITEMS) begin
      pick = $urandom_range(99);
      row = '{KIND_PUSH, 16'($urandom), 4'($urandom), 0, 0, 0};
      if (pick < 55) begin
        if ($urandom_range(9) < 4) begin
          row.sample = 16'(cos_q15[(phase * tone) % 16]);
          phase++;
        end else if ($urandom_range(9) == 0) begin
          row.sample = $urandom_range(1) ? 16'sd32767 : -16'sd32768;
        end
        if ($urandom_range(63) == 0) tone = $urandom_range(15);
      end else if (pick < 78) begin
        row.kind = KIND_MAG;
      end else if (pick < 95) begin
        row.kind = KIND_PEAK;
      end else begin
        row.kind = KIND_UNUSED;
      end
      send_item(row, !(transfers >= 300 && transfers < 450));
      if (row.kind != KIND_UNUSED) n++;
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/sdft_pkg.sv
rtl/core/sdft_dpath.sv
rtl/core/sdft_ctrl.sv
rtl/core/sliding_dft_bins_core.sv
rtl/core/sdft_checker.sv
test/tb_top.sv
